[rtl/ledarb_pkg.sv]
package ledarb_pkg;

    localparam int NUM_SRC = 5;

    localparam logic [2:0] SRC_BATTERY = 3'd0;
    localparam logic [2:0] SRC_NOTIFY  = 3'd1;
    localparam logic [2:0] SRC_ATTN    = 3'd2;
    localparam logic [2:0] SRC_MIC     = 3'd3;
    localparam logic [2:0] SRC_CAMERA  = 3'd4;

    localparam logic [1:0] FLASH_NONE  = 2'd0;
    localparam logic [1:0] FLASH_TIMED = 2'd1;

    localparam logic [2:0] CHG_UNKNOWN  = 3'd0;
    localparam logic [2:0] CHG_FULL     = 3'd1;
    localparam logic [2:0] CHG_DISCHG   = 3'd2;
    localparam logic [2:0] CHG_CHARGING = 3'd3;

    localparam logic [31:0] LIT_MASK   = 32'h00ff_ffff;
    localparam logic [31:0] FAST_COLOR = 32'h10FA_10FA;
    localparam logic [7:0]  BRIGHT_RESET = 8'd200;

    localparam logic [3:0] RISE_BREATH = 4'd3;
    localparam logic [3:0] FALL_BREATH = 4'd5;

    localparam logic [15:0] TIM_LIMIT [15] = '{
        16'd130, 16'd260, 16'd380, 16'd510, 16'd770, 16'd1040, 16'd1600, 16'd2100,
        16'd2600, 16'd3100, 16'd4200, 16'd5200, 16'd6200, 16'd7300, 16'd8300
    };

    typedef enum logic [2:0] {
        LED_OFF    = 3'd0,
        LED_CONST  = 3'd1,
        LED_BLINK  = 3'd2,
        LED_BREATH = 3'd3,
        LED_COLOR  = 3'd4
    } led_mode_t;

    typedef enum logic [2:0] {
        BAT_FREE  = 3'd0,
        BAT_VLOW  = 3'd1,
        BAT_LOW   = 3'd2,
        BAT_CHG   = 3'd3,
        BAT_FAST  = 3'd4,
        BAT_FULL  = 3'd5
    } bat_class_t;

    typedef struct packed {
        logic [31:0] color;
        logic [1:0]  flash;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } pattern_t;

    typedef struct packed {
        led_mode_t   mode;
        logic [31:0] color;
        logic [7:0]  bright;
        logic [3:0]  rise_code;
        logic [3:0]  on_code;
        logic [3:0]  fall_code;
        logic [3:0]  off_code;
    } led_out_t;

    function automatic logic [3:0] time_code(input logic [15:0] t);
        logic [3:0] code;
        code = 4'd15;
        for (int i = 14; i >= 0; i--) begin
            if (t <= TIM_LIMIT[i]) begin
                code = 4'(i);
            end
        end
        return code;
    endfunction

    function automatic logic is_lit(input logic [31:0] c);
        return (c & LIT_MASK) != 32'd0;
    endfunction

endpackage

[rtl/ledarb_bat_adjust.sv]
module ledarb_bat_adjust
    import ledarb_pkg::*;
(
    input  pattern_t   req,
    input  logic [2:0] charge_status,
    input  logic [6:0] capacity,
    input  logic       fast_chg,
    output pattern_t   adj
);

    bat_class_t cls;

    always_comb begin
        case (charge_status)
            CHG_UNKNOWN: cls = BAT_FREE;
            CHG_FULL:    cls = BAT_FULL;
            CHG_DISCHG: begin
                if (capacity > 7'd20) begin
                    cls = BAT_FREE;
                end else if (capacity > 7'd10) begin
                    cls = BAT_LOW;
                end else begin
                    cls = BAT_VLOW;
                end
            end
            CHG_CHARGING: begin
                if (capacity > 7'd80) begin
                    cls = BAT_FULL;
                end else if (fast_chg) begin
                    cls = BAT_FAST;
                end else begin
                    cls = BAT_CHG;
                end
            end
            default: begin
                if (capacity < 7'd10) begin
                    cls = BAT_VLOW;
                end else if (capacity < 7'd20) begin
                    cls = BAT_LOW;
                end else begin
                    cls = BAT_FREE;
                end
            end
        endcase
    end

    always_comb begin
        adj = req;
        case (cls)
            BAT_CHG: begin
                adj.flash  = FLASH_TIMED;
                adj.on_ms  = 16'd1000;
                adj.off_ms = 16'd1500;
            end
            BAT_FAST: begin
                adj.flash  = FLASH_TIMED;
                adj.on_ms  = 16'd800;
                adj.off_ms = 16'd1200;
                adj.color  = FAST_COLOR;
            end
            BAT_LOW: begin
                adj.flash  = FLASH_TIMED;
                adj.on_ms  = 16'd1000;
                adj.off_ms = 16'd4500;
            end
            BAT_VLOW: begin
                adj.flash  = FLASH_TIMED;
                adj.on_ms  = 16'd400;
                adj.off_ms = 16'd6500;
            end
            BAT_FULL: adj.flash = FLASH_NONE;
            default:  adj = req;
        endcase
    end

endmodule

[rtl/ledarb_encode.sv]
module ledarb_encode
    import ledarb_pkg::*;
(
    input  pattern_t   pick,
    input  logic [7:0] brightness_level,
    output led_out_t   led
);

    logic [3:0] on_t;
    logic [3:0] off_t;

    assign on_t  = time_code(pick.on_ms);
    assign off_t = time_code(pick.off_ms);

    always_comb begin
        led = '0;
        if (is_lit(pick.color)) begin
            led.color  = pick.color;
            led.bright = brightness_level;
            case (pick.flash)
                FLASH_NONE: led.mode = LED_CONST;
                FLASH_TIMED: begin
                    if (pick.on_ms == pick.off_ms) begin
                        led.mode     = LED_BLINK;
                        led.on_code  = on_t;
                        led.off_code = on_t;
                    end else begin
                        led.mode      = LED_BREATH;
                        led.rise_code = RISE_BREATH;
                        led.on_code   = on_t;
                        led.fall_code = FALL_BREATH;
                        led.off_code  = off_t;
                    end
                end
                default: led.mode = LED_COLOR;
            endcase
        end
    end

endmodule

[rtl/indicator_led_priority_arbiter.sv]
// An accepted beat passes through the input register, then the result register, before it
// is presented on m_tvalid; the input register holds while a result waits for m_tready.
// Throughput: one beat per cycle while m_tready is high; the input register and the result register
// advance together, and the per-source state of a supported source updates in the same cycle.
// Reset (aresetn low, synchronous): stored patterns, adjusted battery pattern
// and last shown pattern clear to zero, brightness returns to 200.
module indicator_led_priority_arbiter
    import ledarb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // color[31:0], flash_mode[33:32], on_ms[49:34], off_ms[65:50],
    // charge_status[68:66], capacity[75:69], fast_chg[76], zero[79:77]
    input  logic [79:0] s_tdata,
    // source[2:0]
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // written[0], led_mode[3:1], led_color[35:4], brightness[43:36],
    // rise_code[47:44], on_code[51:48], fall_code[55:52], off_code[59:56], zero[63:60]
    output logic [63:0] m_tdata,
    // status[0]
    output logic        m_tuser
);

    logic [7:0]  bright_reg;

    logic        in_valid_reg;
    logic [2:0]  in_src_reg;
    logic [79:0] in_data_reg;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_user_reg;

    pattern_t    src_pat_reg [NUM_SRC];
    pattern_t    src_pat_next [NUM_SRC];
    pattern_t    adj_reg;
    pattern_t    adj_next;
    pattern_t    shown_reg;

    pattern_t    req;
    pattern_t    bat_adj;
    pattern_t    pick;
    led_out_t    led;
    logic        src_ok;
    logic        changed;
    logic        written;
    logic        advance;
    logic [63:0] out_data_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign src_ok     = in_src_reg < 3'(NUM_SRC);
    assign req.color  = in_data_reg[31:0];
    assign req.flash  = in_data_reg[33:32];
    assign req.on_ms  = in_data_reg[49:34];
    assign req.off_ms = in_data_reg[65:50];

    ledarb_bat_adjust u_bat_adjust (
        .req           (req),
        .charge_status (in_data_reg[68:66]),
        .capacity      (in_data_reg[75:69]),
        .fast_chg      (in_data_reg[76]),
        .adj           (bat_adj)
    );

    always_comb begin
        for (int i = 0; i < NUM_SRC; i++) begin
            src_pat_next[i] = (src_ok && in_src_reg == 3'(i)) ? req : src_pat_reg[i];
        end
        adj_next = (src_ok && in_src_reg == SRC_BATTERY) ? bat_adj : adj_reg;
    end

    always_comb begin
        if (is_lit(src_pat_next[SRC_CAMERA].color)) begin
            pick = src_pat_next[SRC_CAMERA];
        end else if (is_lit(src_pat_next[SRC_MIC].color)) begin
            pick = src_pat_next[SRC_MIC];
        end else if (is_lit(src_pat_next[SRC_ATTN].color)) begin
            pick = src_pat_next[SRC_ATTN];
        end else if (is_lit(src_pat_next[SRC_NOTIFY].color)) begin
            pick = src_pat_next[SRC_NOTIFY];
        end else if (is_lit(src_pat_next[SRC_BATTERY].color)
                     && src_pat_next[SRC_BATTERY] != adj_next) begin
            pick = adj_next;
        end else if (is_lit(src_pat_next[SRC_BATTERY].color)) begin
            pick = src_pat_next[SRC_BATTERY];
        end else begin
            pick = '0;
        end
    end

    ledarb_encode u_encode (
        .pick             (pick),
        .brightness_level (bright_reg),
        .led              (led)
    );

    assign changed = pick != shown_reg;
    assign written = src_ok && changed;

    always_comb begin
        out_data_next = '0;
        if (written) begin
            out_data_next = {4'b0, led.off_code, led.fall_code, led.on_code,
                             led.rise_code, led.bright, led.color, led.mode, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg    <= BRIGHT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SRC; i++) begin
                src_pat_reg[i] <= '0;
            end
            adj_reg   <= '0;
            shown_reg <= '0;
        end else begin
            if (cfg_we) begin
                bright_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && src_ok) begin
                for (int i = 0; i < NUM_SRC; i++) begin
                    src_pat_reg[i] <= src_pat_next[i];
                end
                adj_reg <= adj_next;
                if (changed) begin
                    shown_reg <= pick;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_src_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= !src_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_error_not_written: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("error beat carries LED data");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg)
                                     && $stable(in_src_reg))
        else $error("input register lost a stalled beat");

    a_shown_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && written |=> shown_reg != $past(shown_reg))
        else $error("written beat without a new shown pattern");

    a_unsupported_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !src_ok |=> $stable(shown_reg) && $stable(adj_reg))
        else $error("unsupported source changed state");
`endif

endmodule

[tb/indicator_led_priority_arbiter_tb.sv]
module indicator_led_priority_arbiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ledarb_pkg::*;

    localparam logic [1:0] FLASH_HW   = 2'd2;
    localparam logic [1:0] FLASH_RSVD = 2'd3;
    localparam logic [2:0] CHG_OTHER  = 3'd4;
    localparam logic [2:0] CHG_ODD    = 3'd7;
    localparam logic [2:0] SRC_BAD_LO = 3'd5;
    localparam logic [2:0] SRC_BAD_HI = 3'd7;

    localparam logic [6:0] FULL_ABOVE_PCT = 7'd80;
    localparam logic [6:0] FREE_ABOVE_PCT = 7'd20;
    localparam logic [6:0] LOW_ABOVE_PCT  = 7'd10;

    localparam logic [15:0] CHG_ON_MS   = 16'd1000;
    localparam logic [15:0] CHG_OFF_MS  = 16'd1500;
    localparam logic [15:0] FAST_ON_MS  = 16'd800;
    localparam logic [15:0] FAST_OFF_MS = 16'd1200;
    localparam logic [15:0] LOW_ON_MS   = 16'd1000;
    localparam logic [15:0] LOW_OFF_MS  = 16'd4500;
    localparam logic [15:0] VLOW_ON_MS  = 16'd400;
    localparam logic [15:0] VLOW_OFF_MS = 16'd6500;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [2:0]  source;
        logic [31:0] color;
        logic [1:0]  flash;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [2:0]  chg;
        logic [6:0]  cap;
        logic        fast;
    } light_req_t;

    typedef struct packed {
        logic        status;
        logic        written;
        led_mode_t   mode;
        logic [31:0] color;
        logic [7:0]  bright;
        logic [3:0]  rise_code;
        logic [3:0]  on_code;
        logic [3:0]  fall_code;
        logic [3:0]  off_code;
    } led_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    indicator_led_priority_arbiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pattern_t    stored_pat [NUM_SRC];
    pattern_t    adj_bat_pat;
    pattern_t    shown_pat;
    logic [7:0]  bright_level;
    led_result_t expected_leds [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req_id;
    int unsigned hold_ack_id;
    int unsigned hold_left;
    int unsigned errors;
    int unsigned updates_sent;
    int unsigned results_checked;
    int unsigned leds_driven;
    int unsigned rejected;
    int unsigned input_stalls;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic lit_color(input logic [31:0] c);
        return (c & LIT_MASK) != 32'd0;
    endfunction

    function automatic logic [3:0] quantize_ms(input logic [15:0] t);
        for (int i = 0; i < 15; i++) begin
            if (t <= TIM_LIMIT[i]) begin
                return 4'(i);
            end
        end
        return 4'd15;
    endfunction

    function automatic bat_class_t classify_battery(input logic [2:0] chg,
                                                    input logic [6:0] cap,
                                                    input logic fast);
        case (chg)
            CHG_UNKNOWN: return BAT_FREE;
            CHG_FULL:    return BAT_FULL;
            CHG_DISCHG: begin
                if (cap > FREE_ABOVE_PCT) return BAT_FREE;
                if (cap > LOW_ABOVE_PCT) return BAT_LOW;
                return BAT_VLOW;
            end
            CHG_CHARGING: begin
                if (cap > FULL_ABOVE_PCT) return BAT_FULL;
                return fast ? BAT_FAST : BAT_CHG;
            end
            default: begin
                if (cap < LOW_ABOVE_PCT) return BAT_VLOW;
                if (cap < FREE_ABOVE_PCT) return BAT_LOW;
                return BAT_FREE;
            end
        endcase
    endfunction

    function automatic pattern_t make_timed(input pattern_t p, input logic [15:0] on_t,
                                            input logic [15:0] off_t);
        pattern_t q;
        q = p;
        q.flash = FLASH_TIMED;
        q.on_ms = on_t;
        q.off_ms = off_t;
        return q;
    endfunction

    task automatic reset_predictor();
        for (int i = 0; i < NUM_SRC; i++) begin
            stored_pat[i] = '0;
        end
        adj_bat_pat = '0;
        shown_pat = '0;
        bright_level = BRIGHT_RESET;
    endtask

    function automatic led_result_t predict_led(input light_req_t r);
        pattern_t    req;
        pattern_t    pick;
        pattern_t    bat;
        led_result_t res;
        res = '0;
        if (r.source > SRC_CAMERA) begin
            res.status = 1'b1;
            return res;
        end
        req.color = r.color;
        req.flash = r.flash;
        req.on_ms = r.on_ms;
        req.off_ms = r.off_ms;
        stored_pat[r.source] = req;
        if (r.source == SRC_BATTERY) begin
            adj_bat_pat = req;
            case (classify_battery(r.chg, r.cap, r.fast))
                BAT_CHG:  adj_bat_pat = make_timed(req, CHG_ON_MS, CHG_OFF_MS);
                BAT_FAST: begin
                    adj_bat_pat = make_timed(req, FAST_ON_MS, FAST_OFF_MS);
                    adj_bat_pat.color = FAST_COLOR;
                end
                BAT_LOW:  adj_bat_pat = make_timed(req, LOW_ON_MS, LOW_OFF_MS);
                BAT_VLOW: adj_bat_pat = make_timed(req, VLOW_ON_MS, VLOW_OFF_MS);
                BAT_FULL: adj_bat_pat.flash = FLASH_NONE;
                default: ;
            endcase
        end
        bat = stored_pat[SRC_BATTERY];
        pick = '0;
        if (lit_color(stored_pat[SRC_CAMERA].color)) pick = stored_pat[SRC_CAMERA];
        else if (lit_color(stored_pat[SRC_MIC].color)) pick = stored_pat[SRC_MIC];
        else if (lit_color(stored_pat[SRC_ATTN].color)) pick = stored_pat[SRC_ATTN];
        else if (lit_color(stored_pat[SRC_NOTIFY].color)) pick = stored_pat[SRC_NOTIFY];
        else if (lit_color(bat.color) && bat != adj_bat_pat) pick = adj_bat_pat;
        else if (lit_color(bat.color)) pick = bat;
        if (pick == shown_pat) begin
            return res;
        end
        shown_pat = pick;
        res.written = 1'b1;
        if (!lit_color(pick.color)) begin
            return res;
        end
        res.color = pick.color;
        res.bright = bright_level;
        if (pick.flash == FLASH_NONE) begin
            res.mode = LED_CONST;
        end else if (pick.flash == FLASH_TIMED) begin
            res.on_code = quantize_ms(pick.on_ms);
            if (pick.on_ms == pick.off_ms) begin
                res.mode = LED_BLINK;
                res.off_code = res.on_code;
            end else begin
                res.mode = LED_BREATH;
                res.rise_code = RISE_BREATH;
                res.fall_code = FALL_BREATH;
                res.off_code = quantize_ms(pick.off_ms);
            end
        end else begin
            res.mode = LED_COLOR;
        end
        return res;
    endfunction

    // receive side: drive m_tready, hold off on request, check each result beat
    always @(posedge aclk) begin : result_check
        led_result_t seen;
        led_result_t want;
        if (aresetn && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            seen.status = m_tuser;
            seen.written = m_tdata[0];
            seen.mode = led_mode_t'(m_tdata[3:1]);
            seen.color = m_tdata[35:4];
            seen.bright = m_tdata[43:36];
            seen.rise_code = m_tdata[47:44];
            seen.on_code = m_tdata[51:48];
            seen.fall_code = m_tdata[55:52];
            seen.off_code = m_tdata[59:56];
            if (expected_leds.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result beat: st=%0b wr=%0b mode=%0d color=%h",
                             seen.status, seen.written, seen.mode, seen.color);
                end
            end else begin
                want = expected_leds.pop_front();
                results_checked++;
                if (want.written) leds_driven++;
                if (want.status) rejected++;
                if (seen !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at result %0d:", results_checked);
                        $display({"  expected st=%0b wr=%0b mode=%0d color=%h br=%0d",
                                  " codes=%0d/%0d/%0d/%0d"},
                                 want.status, want.written, want.mode, want.color, want.bright,
                                 want.rise_code, want.on_code, want.fall_code, want.off_code);
                        $display({"  actual   st=%0b wr=%0b mode=%0d color=%h br=%0d",
                                  " codes=%0d/%0d/%0d/%0d"},
                                 seen.status, seen.written, seen.mode, seen.color, seen.bright,
                                 seen.rise_code, seen.on_code, seen.fall_code, seen.off_code);
                    end
                end
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req_id != hold_ack_id) begin
            hold_ack_id = hold_req_id;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_light_update(input light_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.source;
        s_tdata <= {3'b000, r.fast, r.cap, r.chg, r.off_ms, r.on_ms, r.flash, r.color};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_leds = {expected_leds, predict_led(r)};
        updates_sent++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (expected_leds.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_brightness(input logic [7:0] level);
        go_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= level;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bright_level = level;
        @(posedge aclk);
    endtask

    function automatic light_req_t make_req(input logic [2:0] src, input logic [31:0] color,
                                            input logic [1:0] flash, input logic [15:0] on_t,
                                            input logic [15:0] off_t,
                                            input logic [2:0] chg = CHG_UNKNOWN,
                                            input logic [6:0] cap = 7'd50,
                                            input logic fast = 1'b0);
        light_req_t r;
        r.source = src;
        r.color = color;
        r.flash = flash;
        r.on_ms = on_t;
        r.off_ms = off_t;
        r.chg = chg;
        r.cap = cap;
        r.fast = fast;
        return r;
    endfunction

    function automatic logic [15:0] rand_ms();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return TIM_LIMIT[$urandom_range(14)] + 16'($urandom_range(1));
        if (roll < 45) return 16'd0;
        if (roll < 50) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    function automatic logic [6:0] rand_capacity();
        int unsigned roll;
        logic [6:0] near [8];
        near = '{7'd9, 7'd10, 7'd11, 7'd19, 7'd20, 7'd21, 7'd80, 7'd81};
        roll = $urandom_range(99);
        if (roll < 60) return near[$urandom_range(7)];
        if (roll < 90) return 7'($urandom_range(100));
        return 7'($urandom_range(127));
    endfunction

    function automatic light_req_t rand_light_req();
        light_req_t r;
        int unsigned roll;
        roll = $urandom_range(99);
        r.source = (roll < 5) ? 3'($urandom_range(SRC_BAD_HI, SRC_BAD_LO))
                              : 3'($urandom_range(SRC_CAMERA, SRC_BATTERY));
        // higher sources go dark more often so the lower ones get shown
        if ($urandom_range(99) < 30 + 12 * r.source) begin
            r.color = $urandom_range(1) ? 32'd0 : {8'($urandom()), 24'd0};
        end else begin
            r.color = $urandom();
            if (!lit_color(r.color)) r.color[0] = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 45) r.flash = FLASH_TIMED;
        else if (roll < 75) r.flash = FLASH_NONE;
        else if (roll < 92) r.flash = FLASH_HW;
        else r.flash = FLASH_RSVD;
        r.on_ms = rand_ms();
        r.off_ms = ($urandom_range(99) < 35) ? r.on_ms : rand_ms();
        r.chg = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
        r.cap = rand_capacity();
        r.fast = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_light_update(make_req(SRC_BATTERY, 32'h00FF0000, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_BATTERY, 32'h00FF0000, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_BATTERY, 32'h0000FF00, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_CHARGING, 7'd50, 1'b0));
        send_light_update(make_req(SRC_BATTERY, 32'h0000FF00, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_CHARGING, 7'd80, 1'b1));
        send_light_update(make_req(SRC_BATTERY, 32'h000000FF, FLASH_TIMED, 16'd500, 16'd500,
                                   CHG_CHARGING, 7'd81, 1'b1));
        send_light_update(make_req(SRC_BATTERY, 32'h000000FF, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_FULL, 7'd0));
        send_light_update(make_req(SRC_BATTERY, 32'h00123456, FLASH_TIMED, 16'd1040, 16'd1041,
                                   CHG_DISCHG, 7'd21));
        send_light_update(make_req(SRC_BATTERY, 32'h00123456, FLASH_TIMED, 16'd1040, 16'd1041,
                                   CHG_DISCHG, 7'd11));
        send_light_update(make_req(SRC_BATTERY, 32'h00123456, FLASH_TIMED, 16'd1040, 16'd1041,
                                   CHG_DISCHG, 7'd10));
        send_light_update(make_req(SRC_BATTERY, 32'h00654321, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_OTHER, 7'd9));
        send_light_update(make_req(SRC_BATTERY, 32'h00654321, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_OTHER, 7'd19));
        send_light_update(make_req(SRC_BATTERY, 32'h00654321, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_OTHER, 7'd20));
        send_light_update(make_req(SRC_BATTERY, 32'h00654321, FLASH_NONE, 16'd0, 16'd0,
                                   CHG_ODD, 7'd127, 1'b1));
        send_light_update(make_req(SRC_NOTIFY, 32'hFFFFFFFF, FLASH_TIMED, 16'd130, 16'd130));
        send_light_update(make_req(SRC_ATTN, 32'h00000001, FLASH_TIMED, 16'd8300, 16'd8301));
        send_light_update(make_req(SRC_MIC, 32'h00ABCDEF, FLASH_HW, 16'hFFFF, 16'd0));
        send_light_update(make_req(SRC_CAMERA, 32'h80000001, FLASH_RSVD, 16'd131, 16'd0));
        send_light_update(make_req(SRC_CAMERA, 32'hFF000000, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_BAD_LO, 32'h00FFFFFF, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_BAD_HI, 32'hFFFFFFFF, FLASH_RSVD, 16'hFFFF, 16'hFFFF,
                                   CHG_ODD, 7'd127, 1'b1));
        send_light_update(make_req(SRC_MIC, 32'd0, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_ATTN, 32'd0, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_NOTIFY, 32'd0, FLASH_NONE, 16'd0, 16'd0));
        send_light_update(make_req(SRC_BATTERY, 32'hFF000000, FLASH_TIMED, 16'd0, 16'hFFFF));
    endtask

    task automatic test_random(input int unsigned count, input int unsigned spct,
                               input int unsigned rpct);
        light_req_t r;
        light_req_t prev;
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        prev = rand_light_req();
        for (int unsigned i = 0; i < count; i++) begin
            r = ($urandom_range(99) < 12) ? prev : rand_light_req();
            send_light_update(r);
            prev = r;
        end
    endtask

    task automatic test_backpressure(input int unsigned count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_id <= hold_req_id + 1;
        for (int unsigned i = 0; i < count; i++) begin
            send_light_update(rand_light_req());
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 8'd0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        hold_req_id = 0;
        hold_ack_id = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        updates_sent = 0;
        results_checked = 0;
        leds_driven = 0;
        rejected = 0;
        input_stalls = 0;
        reset_predictor();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        set_brightness(8'd255);
        test_random(600, 7, 56);
        set_brightness(8'd0);
        test_random(600, 56, 7);
        set_brightness(8'($urandom_range(254, 1)));
        test_backpressure(60);
        test_random(500, 0, 0);
        go_idle();

        if (expected_leds.size() != 0) begin
            errors += expected_leds.size();
        end
        $display("Covered %0d light updates (%0d from unsupported sources), %0d LED drives,",
                 updates_sent, rejected, leds_driven);
        $display({"four brightness levels, three idle mixes and a %0d-cycle output hold",
                  " (%0d stalled input cycles)."},
                 HOLD_CYCLES, input_stalls);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
